@@ hdl/pbra_pkg.sv @@
// Shared constants and controller/datapath handshake types for the
// per-bin running average block. No dependencies.
`default_nettype none
package pbra_pkg;

   localparam int NUM_BINS    = 1024;
   localparam int SAMPLE_BITS = 16;

   localparam int BIN_W     = 10;
   localparam int FIELD_W   = 16;
   localparam int CNT_W     = 16;
   localparam int TIMER_W   = 32;
   localparam int ADDR_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int NUM_W     = SAMPLE_BITS + CNT_W;
   localparam int REM_W     = CNT_W + 1;
   localparam int DIV_CNT_W = $clog2(SAMPLE_BITS);

   localparam logic [CNT_W-1:0]   COUNT_MAX    = '1;
   localparam logic [TIMER_W-1:0] WINDOW_RESET = TIMER_W'(30000);

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef struct packed {
      logic capture;
      logic do_tick;
      logic bump;
      logic mul;
      logic div_load;
      logic div_step;
      logic write;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic bin_ok;
      logic count_zero;
      logic out_free;
   } dp_sts_type;

endpackage
`default_nettype wire

@@ hdl/pbra_req_if.sv @@
// Input channel of the running average block: one sample or tick per item.
// Depends on pbra_pkg.
`default_nettype none
interface pbra_req_if
   import pbra_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [BIN_W-1:0]   bin;
   logic [FIELD_W-1:0] range_in;
   logic [FIELD_W-1:0] intensity_in;
   logic               scan_end;

   modport source (output valid, cmd, bin, range_in, intensity_in, scan_end, input ready);
   modport sink (input valid, cmd, bin, range_in, intensity_in, scan_end, output ready);
endinterface
`default_nettype wire

@@ hdl/pbra_rsp_if.sv @@
// Result channel of the running average block: one averaged bin per item.
// Depends on pbra_pkg.
`default_nettype none
interface pbra_rsp_if
   import pbra_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [BIN_W-1:0]   out_bin;
   logic [FIELD_W-1:0] avg_range;
   logic [FIELD_W-1:0] avg_intensity;
   logic               out_last;

   modport source (output valid, out_bin, avg_range, avg_intensity, out_last, input ready);
   modport sink (input valid, out_bin, avg_range, avg_intensity, out_last, output ready);
endinterface
`default_nettype wire

@@ hdl/per_bin_running_average.sv @@
// Per-bin running average of repeated laser scans, top level.
// Channels: req_ch takes one item per bin sample or timer tick, rsp_ch
//   returns one item holding the bin's new averages for every in-range
//   sample; ticks and out-of-range samples return nothing.
// csr_wr_en/csr_wr_data write the window length in ticks; write only while
//   the block is idle.
// Throughput: one item at a time; req_ch.ready is high only while idle.
//   A tick or an out-of-range sample ends in decode. A sample with no scan
//   averaged yet goes from decode to write-back. An averaging sample passes
//   through multiply, divider load, divide and write-back, the two dividers
//   giving one quotient bit per cycle.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and holds in write-back until that result is taken.
// Reset: synchronous, active high; clears scan count, timer and the output
//   register and restores the window to 30000 ticks. Bin stores are not
//   cleared: the first scan after reset or window expiry overwrites them.
// Depends on pbra_pkg, pbra_req_if, pbra_rsp_if, pbra_ctrl, pbra_dp.
`default_nettype none
module per_bin_running_average
   import pbra_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   pbra_req_if.sink                req_ch,
   pbra_rsp_if.source              rsp_ch,
   input  wire logic               csr_wr_en,
   input  wire logic [TIMER_W-1:0] csr_wr_data
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   logic        ready;

   assign req_ch.ready = ready;

   pbra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pbra_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .sts           (sts),
      .req_cmd       (req_ch.cmd),
      .req_bin       (req_ch.bin),
      .req_range     (req_ch.range_in),
      .req_intensity (req_ch.intensity_in),
      .req_last      (req_ch.scan_end),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_bin       (rsp_ch.out_bin),
      .rsp_range     (rsp_ch.avg_range),
      .rsp_intensity (rsp_ch.avg_intensity),
      .rsp_last      (rsp_ch.out_last)
   );

endmodule
`default_nettype wire

@@ hdl/pbra_div.sv @@
// Restoring divider, one quotient bit per step; quotient fits SAMPLE_BITS.
// Depends on pbra_pkg.
`default_nettype none
module pbra_div
   import pbra_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   load,
   input  wire logic                   step,
   input  wire logic [NUM_W-1:0]       num,
   input  wire logic [REM_W-1:0]       den,
   output logic      [SAMPLE_BITS-1:0] quo
);

   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] quo_ff, quo_in;
   logic [REM_W:0]         trial;
   logic [REM_W:0]         diff;
   logic                   qbit;

   always_comb begin
      trial  = {rem_ff, quo_ff[SAMPLE_BITS-1]};
      diff   = trial - {1'b0, den};
      qbit   = (trial >= {1'b0, den});
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (load) begin
         rem_in = REM_W'(num[NUM_W-1:SAMPLE_BITS]);
         quo_in = num[SAMPLE_BITS-1:0];
      end else if (step) begin
         rem_in = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
         quo_in = {quo_ff[SAMPLE_BITS-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule
`default_nettype wire

@@ hdl/pbra_dp.sv @@
// Datapath: sample stores, scan count, window timer, multiply, dividers and
// the result register. Depends on pbra_pkg and pbra_div.
`default_nettype none
module pbra_dp
   import pbra_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [TIMER_W-1:0] csr_wr_data,
   input  wire ctl_cmd_type        cmd,
   output dp_sts_type              sts,
   input  wire logic               req_cmd,
   input  wire logic [BIN_W-1:0]   req_bin,
   input  wire logic [FIELD_W-1:0] req_range,
   input  wire logic [FIELD_W-1:0] req_intensity,
   input  wire logic               req_last,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic      [BIN_W-1:0]   rsp_bin,
   output logic      [FIELD_W-1:0] rsp_range,
   output logic      [FIELD_W-1:0] rsp_intensity,
   output logic                    rsp_last
);

   logic [SAMPLE_BITS-1:0] range_mem [NUM_BINS];
   logic [SAMPLE_BITS-1:0] inten_mem [NUM_BINS];

   logic                   cmd_ff;
   logic [BIN_W-1:0]       bin_ff;
   logic [SAMPLE_BITS-1:0] rx_ff, ix_ff;
   logic                   last_ff;
   logic [SAMPLE_BITS-1:0] rd_r_ff, rd_i_ff;
   logic [NUM_W-1:0]       prod_r_ff, prod_i_ff;

   logic [TIMER_W-1:0] window_ff, window_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               running_ff, running_in;
   logic [TIMER_W-1:0] elapsed_ff, elapsed_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]       out_bin_ff;
   logic [FIELD_W-1:0]     out_r_ff, out_i_ff;
   logic                   out_last_ff;

   logic [ADDR_W-1:0]      addr;
   logic [REM_W-1:0]       den;
   logic [SAMPLE_BITS-1:0] quo_r, quo_i;
   logic [SAMPLE_BITS-1:0] res_r, res_i;
   logic [TIMER_W:0]       elapsed_next;
   logic                   count_zero;

   assign addr       = ADDR_W'(bin_ff);
   assign count_zero = (count_ff == '0);
   assign den        = {1'b0, count_ff} + REM_W'(1);
   assign res_r      = count_zero ? rx_ff : quo_r;
   assign res_i      = count_zero ? ix_ff : quo_i;

   assign sts.is_tick    = (cmd_ff == CMD_TICK);
   assign sts.bin_ok     = (32'(bin_ff) < 32'(NUM_BINS));
   assign sts.count_zero = count_zero;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_cmd;
         bin_ff  <= req_bin;
         rx_ff   <= SAMPLE_BITS'(req_range);
         ix_ff   <= SAMPLE_BITS'(req_intensity);
         last_ff <= req_last;
      end
      rd_r_ff <= range_mem[addr];
      rd_i_ff <= inten_mem[addr];
      if (cmd.write) begin
         range_mem[addr] <= res_r;
         inten_mem[addr] <= res_i;
      end
      if (cmd.mul) begin
         prod_r_ff <= NUM_W'(rd_r_ff) * NUM_W'(count_ff);
         prod_i_ff <= NUM_W'(rd_i_ff) * NUM_W'(count_ff);
      end
   end

   pbra_div u_div_range (
      .clock (clock),
      .load  (cmd.div_load),
      .step  (cmd.div_step),
      .num   (prod_r_ff + NUM_W'(rx_ff)),
      .den   (den),
      .quo   (quo_r)
   );

   pbra_div u_div_inten (
      .clock (clock),
      .load  (cmd.div_load),
      .step  (cmd.div_step),
      .num   (prod_i_ff + NUM_W'(ix_ff)),
      .den   (den),
      .quo   (quo_i)
   );

   // window timer and scan count
   always_comb begin
      window_in    = csr_wr_en ? csr_wr_data : window_ff;
      count_in     = count_ff;
      running_in   = running_ff;
      elapsed_in   = elapsed_ff;
      elapsed_next = {1'b0, elapsed_ff} + (TIMER_W+1)'(1);
      if (cmd.do_tick && running_ff) begin
         if (elapsed_next >= {1'b0, window_ff}) begin
            count_in   = '0;
            running_in = 1'b0;
            elapsed_in = '0;
         end else begin
            elapsed_in = elapsed_next[TIMER_W-1:0];
         end
      end
      if (cmd.write && count_zero && !running_ff) begin
         running_in = 1'b1;
         elapsed_in = '0;
      end
      if (cmd.bump && last_ff && count_ff != COUNT_MAX) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         count_ff   <= '0;
         running_ff <= 1'b0;
         elapsed_ff <= '0;
      end else begin
         window_ff  <= window_in;
         count_ff   <= count_in;
         running_ff <= running_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // result register
   assign rsp_valid_in = cmd.write ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         out_bin_ff  <= bin_ff;
         out_r_ff    <= FIELD_W'(res_r);
         out_i_ff    <= FIELD_W'(res_i);
         out_last_ff <= last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin       = out_bin_ff;
   assign rsp_range     = out_r_ff;
   assign rsp_intensity = out_i_ff;
   assign rsp_last      = out_last_ff;

endmodule
`default_nettype wire

@@ hdl/pbra_ctrl.sv @@
// Controller: sequences decode, read, multiply, divide and write-back for
// each item. Depends on pbra_pkg.
`default_nettype none
module pbra_ctrl
   import pbra_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire dp_sts_type sts,
   output ctl_cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_WRITE  = 3'd5;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SAMPLE_BITS - 1);

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.is_tick) begin
               cmd.do_tick = 1'b1;
               state_in    = ST_IDLE;
            end else if (!sts.bin_ok) begin
               cmd.bump = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.count_zero) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               cmd.write = 1'b1;
               cmd.bump  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTH
   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_DECODE))
      else $error("accepted item did not enter decode");

   a_write_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (state_ff == ST_WRITE && sts.out_free))
      else $error("write-back while result register full");

   a_div_full_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == DIV_LAST) |=> (state_ff == ST_WRITE))
      else $error("divider did not finish after all quotient bits");

   a_one_bump: assert property (@(posedge clock) disable iff (reset)
      cmd.bump |=> !cmd.bump)
      else $error("scan count bumped twice for one item");
`endif

endmodule
`default_nettype wire
